### rtl/rsce_pkg.sv
// types, codes and saturating arithmetic for the rotamer search cost evaluator
package rsce_pkg;

  localparam int CNT_W = 5;   // rotamer count width
  localparam int ROT_W = 4;   // rotamer choice width
  localparam int ACC_W = 48;  // accumulator width
  localparam int SUM_W = 18;  // energy address sum before wrap

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam acc_t ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [2:0] {
    REQ_ENERGY = 3'd0,
    REQ_OFFSET = 3'd1,
    REQ_COUNT  = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_APPEND = 3'd4,
    REQ_QUERY  = 3'd5,
    REQ_TOTAL  = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G,
    ST_H_J,
    ST_H_S,
    ST_H_I,
    ST_H_K,
    ST_H_U,
    ST_T,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RET_G,
    RET_HI,
    RET_HU,
    RET_T
  } ret_e;

  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

### rtl/rotamer_search_cost_evaluator.sv
// top level of the rotamer search cost evaluator
//
// loads (energy word, pair offset, rotamer count), clear and append need no
// walk: the result strobe comes in the cycle after start and busy stays low.
// a total or cost query walks the energy store one word at a time; every word
// goes through issue from the loop, assignment read, second assignment and pair
// base read, energy read and accumulate, in an order set by the single read
// port of each memory, with loop control per residue and per rotamer on top.
// busy is high for the whole walk and falls in the cycle the result strobe is
// shown. the receiver cannot stall: the done strobe marks every result for one cycle.
// energy addresses wrap modulo ENERGY_WORDS, which must be a power of two.
module rotamer_search_cost_evaluator
  import rsce_pkg::*;
#(
  parameter int MAX_RESIDUES = 32,
  parameter int MAX_ROTAMERS = 16,
  parameter int ENERGY_WORDS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         req_type_i,
  input  logic [4:0]         residue_a_i,
  input  logic [4:0]         residue_b_i,
  input  logic [15:0]        energy_address_i,
  input  logic signed [31:0] energy_value_i,
  input  logic [15:0]        pair_offset_i,
  input  logic [4:0]         rotamer_count_i,
  input  logic [3:0]         rotamer_choice_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [47:0] g_delta_o,
  output logic signed [47:0] h_bound_o,
  output logic signed [47:0] total_energy_o
);

  localparam int RW  = $clog2(MAX_RESIDUES);
  localparam int CW  = $clog2(MAX_RESIDUES + 1);
  localparam int PBD = MAX_RESIDUES * MAX_RESIDUES;
  localparam int PW  = $clog2(PBD);
  localparam int AW  = $clog2(ENERGY_WORDS);

  // memories
  logic signed [31:0] energy_mem [ENERGY_WORDS];
  logic [15:0]        base_mem [PBD];
  logic [ROT_W-1:0]   asg_mem [MAX_RESIDUES];
  logic [CNT_W-1:0]   cnt_q [MAX_RESIDUES];

  logic signed [31:0] e_rd_q;
  logic [15:0]        base_rd_q;
  logic [ROT_W-1:0]   asg_rd_q;

  // control and loop state
  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic [5:0]    cfg_q;
  logic [CW-1:0] d_q, d_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0] s_q, s_d, u_q, u_d;
  acc_t g_q, g_d, h_q, h_d, tot_q, tot_d;
  acc_t best_q, best_d, sum_q, sum_d, m_q, m_d;
  logic [1:0] stat_q, stat_d;

  // fetch operands
  logic [RW-1:0]    fa_q, fa_d, fb_q, fb_d;
  logic [CNT_W-1:0] fx_q, fx_d, fy_q, fy_d, xv_q, xv_d, cntb_q, cntb_d;
  logic             fxa_q, fxa_d, fya_q, fya_d;

  // result registers
  logic       out_v_q, out_v_d;
  logic [1:0] out_st_q, out_st_d;
  acc_t       out_g_q, out_g_d, out_h_q, out_h_d, out_t_q, out_t_d;

  logic          accept;
  req_e          req;
  logic [CW-1:0] n_w;
  logic [RW-1:0] cnt_idx;
  logic [CNT_W-1:0] cnt_rd;
  logic          g_more;
  logic [CW:0]   i_plus2;
  logic [CNT_W-1:0] y_w;
  logic [SUM_W-1:0] addr_sum;
  logic [AW-1:0] e_raddr;
  logic [RW-1:0] asg_raddr;
  logic [PW-1:0] base_raddr, base_waddr;
  acc_t          e_ext;
  logic          ra_ok, rb_ok;

  assign accept = start_i && !busy_o;
  assign req    = req_e'(req_type_i);
  assign busy_o = (state_q != ST_IDLE);

  // residue_count above the array size acts as the array size
  assign n_w = (32'(cfg_q) > 32'(MAX_RESIDUES)) ? CW'(MAX_RESIDUES) : CW'(cfg_q);

  assign ra_ok = 32'(residue_a_i) < 32'(MAX_RESIDUES);
  assign rb_ok = 32'(residue_b_i) < 32'(MAX_RESIDUES);

  // one read port into the count table, steered by the current loop
  always_comb begin
    unique case (state_q)
      ST_H_S:  cnt_idx = j_q[RW-1:0];
      ST_H_U:  cnt_idx = k_q[RW-1:0];
      ST_F1:   cnt_idx = fb_q;
      default: cnt_idx = d_q[RW-1:0];
    endcase
  end
  assign cnt_rd = cnt_q[cnt_idx];

  assign g_more  = (d_q != '0) && (k_q < d_q - 1'b1);
  assign i_plus2 = {1'b0, i_q} + (CW+1)'(2);

  // energy address: base + x * count(b) + y, wrapped to the store
  assign y_w      = fya_q ? {1'b0, asg_rd_q} : fy_q;
  assign addr_sum = SUM_W'(base_rd_q) + SUM_W'(xv_q) * SUM_W'(cntb_q) + SUM_W'(y_w);
  assign e_raddr  = AW'(addr_sum);
  assign e_ext    = {{(ACC_W-32){e_rd_q[31]}}, e_rd_q};

  assign asg_raddr  = (state_q == ST_F0) ? fa_q : fb_q;
  assign base_raddr = PW'(int'(fa_q) * MAX_RESIDUES + int'(fb_q));
  assign base_waddr = PW'(int'(residue_a_i) * MAX_RESIDUES + int'(residue_b_i));

  logic e_we, b_we, a_we, c_we;
  assign e_we = accept && (req == REQ_ENERGY) &&
                (32'(energy_address_i) < 32'(ENERGY_WORDS));
  assign b_we = accept && (req == REQ_OFFSET) && ra_ok && rb_ok;
  assign c_we = accept && (req == REQ_COUNT) && ra_ok &&
                (32'(rotamer_count_i) <= 32'(MAX_ROTAMERS));
  assign a_we = accept && (req == REQ_APPEND) && (d_q < n_w) &&
                (32'(d_q) < 32'(MAX_RESIDUES)) && ({1'b0, rotamer_choice_i} < cnt_rd);

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      energy_mem[AW'(energy_address_i)] <= energy_value_i;
    end
    e_rd_q <= energy_mem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      base_mem[base_waddr] <= pair_offset_i;
    end
    base_rd_q <= base_mem[base_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      asg_mem[d_q[RW-1:0]] <= rotamer_choice_i;
    end
    asg_rd_q <= asg_mem[asg_raddr];
  end

  // counts reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_RESIDUES; r++) begin
        cnt_q[r] <= '0;
      end
    end else if (c_we) begin
      cnt_q[RW'(residue_a_i)] <= rotamer_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 6'd1;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req == REQ_QUERY) begin
          state_d = ST_G;
        end else if (accept && req == REQ_TOTAL && d_q >= n_w) begin
          state_d = ST_T;
        end
      end
      ST_G:    state_d = g_more ? ST_F0 : ST_H_J;
      ST_H_J:  state_d = (j_q < n_w) ? ST_H_S : ST_DONE;
      ST_H_S:  state_d = (s_q < cnt_rd) ? ST_H_I : ST_H_J;
      ST_H_I:  state_d = (i_q < d_q) ? ST_F0 : ST_H_K;
      ST_H_K:  state_d = (k_q < n_w) ? ST_H_U : ST_H_S;
      ST_H_U:  state_d = (u_q < cnt_rd) ? ST_F0 : ST_H_K;
      ST_T: begin
        priority if (j_q < n_w) begin
          state_d = ST_F0;
        end else if (i_plus2 < {1'b0, n_w}) begin
          state_d = ST_T;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_F0:   state_d = ST_F1;
      ST_F1:   state_d = ST_F2;
      ST_F2:   state_d = ST_F3;
      ST_F3: begin
        unique case (ret_q)
          RET_G:   state_d = ST_G;
          RET_HI:  state_d = ST_H_I;
          RET_HU:  state_d = ST_H_U;
          RET_T:   state_d = ST_T;
          default: state_d = ST_G;
        endcase
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ret_d = ret_q; d_d = d_q;
    i_d = i_q; j_d = j_q; k_d = k_q; s_d = s_q; u_d = u_q;
    g_d = g_q; h_d = h_q; tot_d = tot_q;
    best_d = best_q; sum_d = sum_q; m_d = m_q; stat_d = stat_q;
    fa_d = fa_q; fb_d = fb_q; fx_d = fx_q; fy_d = fy_q;
    fxa_d = fxa_q; fya_d = fya_q;
    xv_d = xv_q; cntb_d = cntb_q;
    out_v_d = 1'b0; out_st_d = out_st_q;
    out_g_d = out_g_q; out_h_d = out_h_q; out_t_d = out_t_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_st_d = STAT_OK;
          out_g_d  = '0;
          out_h_d  = '0;
          out_t_d  = '0;
          unique case (req)
            REQ_ENERGY: begin
              out_v_d = 1'b1;
              if (!e_we) out_st_d = STAT_RANGE;
            end
            REQ_OFFSET: begin
              out_v_d = 1'b1;
              if (!b_we) out_st_d = STAT_RANGE;
            end
            REQ_COUNT: begin
              out_v_d = 1'b1;
              if (!c_we) out_st_d = STAT_RANGE;
            end
            REQ_CLEAR: begin
              out_v_d = 1'b1;
              d_d     = '0;
            end
            REQ_APPEND: begin
              out_v_d = 1'b1;
              priority if (d_q >= n_w || 32'(d_q) >= 32'(MAX_RESIDUES)) begin
                out_st_d = STAT_EMPTY;
              end else if ({1'b0, rotamer_choice_i} >= cnt_rd) begin
                out_st_d = STAT_RANGE;
              end else begin
                d_d = d_q + 1'b1;
              end
            end
            REQ_QUERY: begin
              g_d    = '0;
              h_d    = '0;
              tot_d  = '0;
              k_d    = '0;
              stat_d = (d_q == '0) ? STAT_EMPTY : STAT_OK;
            end
            REQ_TOTAL: begin
              if (d_q < n_w) begin
                out_v_d  = 1'b1;
                out_st_d = STAT_EMPTY;
              end else begin
                g_d    = '0;
                h_d    = '0;
                tot_d  = '0;
                i_d    = '0;
                j_d    = CW'(1);
                stat_d = STAT_OK;
              end
            end
            default: begin
              out_v_d  = 1'b1;
              out_st_d = STAT_RANGE;
            end
          endcase
        end
      end
      ST_G: begin
        if (g_more) begin
          fa_d = k_q[RW-1:0]; fb_d = RW'(d_q - 1'b1);
          fxa_d = 1'b1; fya_d = 1'b1; ret_d = RET_G;
        end else begin
          j_d = d_q;
        end
      end
      ST_H_J: begin
        best_d = ACC_MAX;
        s_d    = '0;
      end
      ST_H_S: begin
        if (s_q < cnt_rd) begin
          sum_d = '0;
          i_d   = '0;
        end else begin
          h_d = sat_add(h_q, best_q);
          j_d = j_q + 1'b1;
        end
      end
      ST_H_I: begin
        if (i_q < d_q) begin
          fa_d = i_q[RW-1:0]; fb_d = j_q[RW-1:0];
          fxa_d = 1'b1; fya_d = 1'b0; fy_d = s_q; ret_d = RET_HI;
        end else begin
          k_d = j_q;
        end
      end
      ST_H_K: begin
        if (k_q < n_w) begin
          m_d = ACC_MAX;
          u_d = '0;
        end else begin
          if (sum_q < best_q) best_d = sum_q;
          s_d = s_q + 1'b1;
        end
      end
      ST_H_U: begin
        if (u_q < cnt_rd) begin
          fa_d = j_q[RW-1:0]; fb_d = k_q[RW-1:0];
          fxa_d = 1'b0; fx_d = s_q; fya_d = 1'b0; fy_d = u_q; ret_d = RET_HU;
        end else begin
          sum_d = sat_add(sum_q, m_q);
          k_d   = k_q + 1'b1;
        end
      end
      ST_T: begin
        if (j_q < n_w) begin
          fa_d = i_q[RW-1:0]; fb_d = j_q[RW-1:0];
          fxa_d = 1'b1; fya_d = 1'b1; ret_d = RET_T;
        end else if (i_plus2 < {1'b0, n_w}) begin
          i_d = i_q + 1'b1;
          j_d = CW'(i_plus2);
        end
      end
      ST_F0: ;
      ST_F1: begin
        xv_d   = fxa_q ? {1'b0, asg_rd_q} : fx_q;
        cntb_d = cnt_rd;
      end
      ST_F2: ;
      ST_F3: begin
        unique case (ret_q)
          RET_G: begin
            g_d = sat_add(g_q, e_ext);
            k_d = k_q + 1'b1;
          end
          RET_HI: begin
            sum_d = sat_add(sum_q, e_ext);
            i_d   = i_q + 1'b1;
          end
          RET_HU: begin
            if (e_ext < m_q) m_d = e_ext;
            u_d = u_q + 1'b1;
          end
          RET_T: begin
            tot_d = sat_add(tot_q, e_ext);
            j_d   = j_q + 1'b1;
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        out_v_d  = 1'b1;
        out_st_d = stat_q;
        out_g_d  = g_q;
        out_h_d  = h_q;
        out_t_d  = tot_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      d_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      d_q     <= d_d;
      out_v_q <= out_v_d;
    end
  end

  // payload and loop registers
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d;
    i_q <= i_d; j_q <= j_d; k_q <= k_d; s_q <= s_d; u_q <= u_d;
    g_q <= g_d; h_q <= h_d; tot_q <= tot_d;
    best_q <= best_d; sum_q <= sum_d; m_q <= m_d; stat_q <= stat_d;
    fa_q <= fa_d; fb_q <= fb_d; fx_q <= fx_d; fy_q <= fy_d;
    fxa_q <= fxa_d; fya_q <= fya_d; xv_q <= xv_d; cntb_q <= cntb_d;
    out_st_q <= out_st_d;
    out_g_q <= out_g_d; out_h_q <= out_h_d; out_t_q <= out_t_d;
  end

  assign done_o         = out_v_q;
  assign status_o       = out_st_q;
  assign g_delta_o      = out_g_q;
  assign h_bound_o      = out_h_q;
  assign total_energy_o = out_t_q;

endmodule

### rtl/rsce_checker.sv
// port-level checker for the rotamer search cost evaluator, with its bind
module rsce_checker
  import rsce_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [2:0] req_type_i,
  input logic       done_o
);

  // a load or clear answers in the next cycle without going busy
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_type_i == REQ_ENERGY || req_type_i == REQ_OFFSET ||
    req_type_i == REQ_COUNT || req_type_i == REQ_CLEAR) |=> done_o && !busy_o)
    else $error("load item did not answer in one cycle");

  // a cost query always goes busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_type_i == REQ_QUERY |=> busy_o && !done_o)
    else $error("cost query did not start a walk");

  // the end of a walk shows its result
  a_end_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("walk ended without a result");

  a_no_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_o && busy_o))
    else $error("result shown while busy");

endmodule

bind rotamer_search_cost_evaluator rsce_checker u_rsce_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .req_type_i (req_type_i),
  .done_o     (done_o)
);

### sim/tb.sv
// self-checking testbench for the rotamer search cost evaluator
`timescale 1ns / 1ps

module tb;
  import rsce_pkg::*;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam int HI_LO = 65532;  // start of the upper block of energy words we load
  localparam int LO_N = 8;       // size of the lower block of energy words we load
  localparam int N_ACT = 4;      // residues that may hold rotamers in random traffic
  localparam int MAX_PICK = 2;   // largest rotamer count in random traffic

  typedef struct packed {
    req_e        req;
    logic [4:0]  res_a;
    logic [4:0]  res_b;
    logic [15:0] addr;
    logic [31:0] val;
    logic [15:0] off;
    logic [4:0]  cnt;
    logic [3:0]  choice;
  } req_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [47:0] g;
    logic signed [47:0] h;
    logic signed [47:0] tot;
  } cost_res_t;

  typedef struct packed {
    req_item_t item;
    bit        typed;
    cost_res_t want;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [5:0]         cfg_wdata_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         req_type_i = '0;
  logic [4:0]         residue_a_i = '0;
  logic [4:0]         residue_b_i = '0;
  logic [15:0]        energy_address_i = '0;
  logic signed [31:0] energy_value_i = '0;
  logic [15:0]        pair_offset_i = '0;
  logic [4:0]         rotamer_count_i = '0;
  logic [3:0]         rotamer_choice_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [47:0] g_delta_o;
  logic signed [47:0] h_bound_o;
  logic signed [47:0] total_energy_o;

  always #1 clk_i = ~clk_i;

  rotamer_search_cost_evaluator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .residue_a_i      (residue_a_i),
    .residue_b_i      (residue_b_i),
    .energy_address_i (energy_address_i),
    .energy_value_i   (energy_value_i),
    .pair_offset_i    (pair_offset_i),
    .rotamer_count_i  (rotamer_count_i),
    .rotamer_choice_i (rotamer_choice_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .g_delta_o        (g_delta_o),
    .h_bound_o        (h_bound_o),
    .total_energy_o   (total_energy_o)
  );

  // shadow copy of the block's tables and assignment
  logic signed [31:0] word_mem [65536];
  logic [15:0]        base_mem [1024];
  logic [4:0]         cnt_mem  [32];
  logic [3:0]         pick_mem [32];
  int                 pick_len;
  int                 res_cfg;

  cost_res_t cost_q [$];  // results still owed by the block
  int  n_fail;
  int  n_items;
  int  n_checked;
  int  n_queries;

  function automatic longint acc_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // energy of residue pair (ra,rb) at rotamers (x,y)
  function automatic longint pair_word(int ra, int rb, int x, int y);
    int ad;
    ad = (int'(base_mem[ra*32+rb]) + x * int'(cnt_mem[rb]) + y) % 65536;
    return longint'(word_mem[ad]);
  endfunction

  // cheapest rotamer of unassigned residue j, fixed part plus floors of j and later residues
  function automatic longint residue_floor(int j, int d, int n);
    longint best, sum, m, e;
    best = ACC_HI;
    for (int s = 0; s < cnt_mem[j]; s++) begin
      sum = 0;
      for (int i = 0; i < d; i++) sum = acc_add(sum, pair_word(i, j, pick_mem[i], s));
      for (int k = j; k < n; k++) begin
        m = ACC_HI;
        for (int u = 0; u < cnt_mem[k]; u++) begin
          e = pair_word(j, k, s, u);
          if (e < m) m = e;
        end
        sum = acc_add(sum, m);
      end
      if (sum < best) best = sum;
    end
    return best;
  endfunction

  // apply one item to the shadow state and return what the block should answer
  function automatic cost_res_t apply_item(req_item_t it);
    cost_res_t r;
    int n, d;
    longint g, h, t;
    n = (res_cfg > 32) ? 32 : res_cfg;
    d = pick_len;
    g = 0; h = 0; t = 0;
    r.status = STAT_OK;
    case (it.req)
      REQ_ENERGY: word_mem[it.addr] = it.val;
      REQ_OFFSET: base_mem[it.res_a*32+it.res_b] = it.off;
      REQ_COUNT: begin
        if (it.cnt <= 16) cnt_mem[it.res_a] = it.cnt;
        else r.status = STAT_RANGE;
      end
      REQ_CLEAR: pick_len = 0;
      REQ_APPEND: begin
        if (d >= n) r.status = STAT_EMPTY;
        else if (it.choice >= cnt_mem[d]) r.status = STAT_RANGE;
        else begin
          pick_mem[d] = it.choice;
          pick_len = d + 1;
        end
      end
      REQ_QUERY: begin
        if (d == 0) r.status = STAT_EMPTY;
        else
          for (int k = 0; k < d - 1; k++)
            g = acc_add(g, pair_word(k, d - 1, pick_mem[k], pick_mem[d-1]));
        for (int j = d; j < n; j++) h = acc_add(h, residue_floor(j, d, n));
      end
      REQ_TOTAL: begin
        if (d < n) r.status = STAT_EMPTY;
        else
          for (int i = 0; i + 1 < n; i++)
            for (int j = i + 1; j < n; j++)
              t = acc_add(t, pair_word(i, j, pick_mem[i], pick_mem[j]));
      end
      default: r.status = STAT_RANGE;
    endcase
    r.g = g[47:0];
    r.h = h[47:0];
    r.tot = t[47:0];
    return r;
  endfunction

  // drive one item after a random gap, wait for acceptance, log the expectation
  task automatic issue(input req_item_t it, input bit typed, input cost_res_t want);
    int gap;
    cost_res_t r;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    req_type_i       <= it.req;
    residue_a_i      <= it.res_a;
    residue_b_i      <= it.res_b;
    energy_address_i <= it.addr;
    energy_value_i   <= it.val;
    pair_offset_i    <= it.off;
    rotamer_count_i  <= it.cnt;
    rotamer_choice_i <= it.choice;
    do @(posedge clk_i); while (busy_o);
    r = apply_item(it);
    if (it.req == REQ_QUERY) n_queries++;
    cost_q.push_back(typed ? want : r);
    n_items++;
  endtask

  // random item of the given kind; reads always land on loaded words and bases
  function automatic req_item_t rand_item(req_e kind);
    req_item_t it;
    it.req    = kind;
    it.res_a  = 5'($urandom);
    it.res_b  = 5'($urandom);
    it.val    = $urandom;
    it.cnt    = 5'($urandom);
    it.choice = 4'($urandom);
    // either a loaded word or anywhere: writing never hurts
    case ($urandom_range(0, 2))
      0: it.addr = 16'($urandom_range(0, LO_N - 1));
      1: it.addr = 16'($urandom_range(HI_LO, 65535));
      default: it.addr = 16'($urandom);
    endcase
    // bases keep every read inside the loaded words, wrapping ones included
    it.off = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, LO_N - 4)) :
                                           16'($urandom_range(HI_LO, 65535));
    if (kind == REQ_COUNT) begin
      if (int'(it.res_a) >= N_ACT) begin
        it.cnt = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
      end else begin
        case ($urandom_range(0, 7))
          0: it.cnt = 5'($urandom_range(17, 31));
          default: it.cnt = 5'($urandom_range(0, MAX_PICK));
        endcase
      end
    end
    return it;
  endfunction

  // let the block drain, then write the residue count
  task automatic set_residues(input int v);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 6'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    res_cfg = v;
  endtask

  // reset-state rows, later loads and appends carry answers; later queries and totals use the predictor
  localparam int N_EARLY = 7;
  localparam dir_row_t DIR_TAB [18] = '{
    '{'{REQ_QUERY, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b1,
      '{STAT_EMPTY, 48'sd0, ACC_MAX, 48'sd0}},
    '{'{REQ_TOTAL, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b1,
      '{STAT_EMPTY, 48'sd0, 48'sd0, 48'sd0}},
    '{'{req_e'(3'd7), 5'd31, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 4'd15}, 1'b1,
      '{STAT_RANGE, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_COUNT, 5'd31, 5'd0, 16'd0, 32'd0, 16'd0, 5'd17, 4'd0}, 1'b1,
      '{STAT_RANGE, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_APPEND, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b1,
      '{STAT_RANGE, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_CLEAR, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b1,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_COUNT, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd31, 4'd0}, 1'b1,
      '{STAT_RANGE, 48'sd0, 48'sd0, 48'sd0}},
    // after the tables are loaded
    '{'{REQ_ENERGY, 5'd0, 5'd0, 16'd0, 32'h7FFF_FFFF, 16'd0, 5'd0, 4'd0}, 1'b1,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_ENERGY, 5'd0, 5'd0, 16'd1, 32'h8000_0000, 16'd0, 5'd0, 4'd0}, 1'b1,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_COUNT, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd16, 4'd0}, 1'b1,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_QUERY, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b0,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_APPEND, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd15}, 1'b1,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    // one residue only, so the list is full now
    '{'{REQ_APPEND, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b1,
      '{STAT_EMPTY, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_QUERY, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b0,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_TOTAL, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b0,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    // wrapping base on the last pair
    '{'{REQ_OFFSET, 5'd31, 5'd31, 16'd0, 32'd0, 16'hFFFF, 5'd0, 4'd0}, 1'b1,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_COUNT, 5'd31, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b1,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}},
    '{'{REQ_QUERY, 5'd0, 5'd0, 16'd0, 32'd0, 16'd0, 5'd0, 4'd0}, 1'b0,
      '{STAT_OK, 48'sd0, 48'sd0, 48'sd0}}
  };

  // 40 checks the clamp to the array size; unused residues saturate the bound
  localparam int N_PHASE = 5;
  localparam int PHASE_RES [N_PHASE] = '{4, 1, 3, 40, 2};

  // compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (cost_q.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d g %0d h %0d total %0d",
                 $time, status_o, g_delta_o, h_bound_o, total_energy_o);
        n_fail++;
      end else begin
        if (status_o !== cost_q[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time, cost_q[0].status, status_o);
          n_fail++;
        end
        if (g_delta_o !== cost_q[0].g) begin
          $display("%0t: g_delta expected %0d actual %0d", $time, cost_q[0].g, g_delta_o);
          n_fail++;
        end
        if (h_bound_o !== cost_q[0].h) begin
          $display("%0t: h_bound expected %0d actual %0d", $time, cost_q[0].h, h_bound_o);
          n_fail++;
        end
        if (total_energy_o !== cost_q[0].tot) begin
          $display("%0t: total_energy expected %0d actual %0d", $time, cost_q[0].tot,
                   total_energy_o);
          n_fail++;
        end
        void'(cost_q.pop_front());
        n_checked++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $display("timed out with %0d results outstanding", cost_q.size());
    $finish;
  end

  initial begin
    req_item_t it;
    cost_res_t none;
    int        n, phase_items;
    n_fail = 0; n_items = 0; n_checked = 0; n_queries = 0;
    none = '0;
    for (int i = 0; i < 32; i++) cnt_mem[i] = '0;
    pick_len = 0;
    res_cfg = 1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset-state corners
    for (int r = 0; r < N_EARLY; r++) issue(DIR_TAB[r].item, DIR_TAB[r].typed, DIR_TAB[r].want);

    // load both energy word blocks and the pair bases of the residues in use
    for (int a = 0; a < LO_N; a++) begin
      it = rand_item(REQ_ENERGY);
      it.addr = 16'(a);
      issue(it, 1'b0, none);
    end
    for (int a = HI_LO; a < 65536; a++) begin
      it = rand_item(REQ_ENERGY);
      it.addr = 16'(a);
      issue(it, 1'b0, none);
    end
    for (int p = 0; p < N_ACT * N_ACT; p++) begin
      it = rand_item(REQ_OFFSET);
      it.res_a = 5'(p / N_ACT);
      it.res_b = 5'(p % N_ACT);
      issue(it, 1'b0, none);
    end

    for (int r = N_EARLY; r < 18; r++) issue(DIR_TAB[r].item, DIR_TAB[r].typed, DIR_TAB[r].want);

    // random phases over several residue counts
    for (int ph = 0; ph < N_PHASE; ph++) begin
      n = PHASE_RES[ph];
      set_residues(n);
      // small rotamer counts on the residues in use, then a fresh assignment
      for (int r = 0; r < N_ACT; r++) begin
        it = rand_item(REQ_COUNT);
        it.res_a = 5'(r);
        it.cnt = 5'($urandom_range(1, MAX_PICK));
        issue(it, 1'b0, none);
      end
      issue(rand_item(REQ_CLEAR), 1'b0, none);
      phase_items = 0;
      while (phase_items < 14) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed: clear, fill with legal rotamers, query along the way, total
          issue(rand_item(REQ_CLEAR), 1'b0, none);
          phase_items++;
          while (pick_len < n && cnt_mem[pick_len] != 0) begin
            it = rand_item(REQ_APPEND);
            it.choice = 4'($urandom_range(0, cnt_mem[pick_len] - 1));
            issue(it, 1'b0, none);
            phase_items++;
            if ($urandom_range(0, 1) == 0) begin
              issue(rand_item(REQ_QUERY), 1'b0, none);
              phase_items++;
            end
          end
          issue(rand_item(REQ_QUERY), 1'b0, none);
          issue(rand_item(REQ_TOTAL), 1'b0, none);
          phase_items += 2;
        end else begin
          // noise: any request type, unknown codes and bad appends included
          repeat ($urandom_range(1, 4)) begin
            it = rand_item(req_e'($urandom_range(0, 7)));
            issue(it, 1'b0, none);
            phase_items++;
          end
        end
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d items sent over %0d residue settings, %0d results checked",
             n_items, N_PHASE, n_checked);
    $display("%0d cost queries, %0d mismatches", n_queries, n_fail);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
